[design/dtq_pkg.sv]
package dtq_pkg;

  localparam int MAX_Q_BITS = 26;
  localparam int QW = 5;
  localparam int WHOLE_W = 32;
  localparam int FRAC_W = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [QW-1:0] Q_BITS_RESET = QW'(16);
  localparam logic [FRAC_W-1:0] WEIGHT_RESET = FRAC_W'(5);

  localparam logic REG_Q_BITS = 1'b0;

  typedef enum logic [1:0] {
    OP_DIGIT,
    OP_POINT,
    OP_OTHER,
    OP_TERM
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
  } op_beat_t;

  function automatic logic [QW-1:0] eff_q(input logic [QW-1:0] q);
    return (q > QW'(MAX_Q_BITS)) ? QW'(MAX_Q_BITS) : q;
  endfunction

endpackage

[design/dtq_in_if.sv]
interface dtq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

[design/dtq_out_if.sv]
interface dtq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] q_value;
  logic        no_point;

  modport source (output valid, output q_value, output no_point, input ready);
  modport sink (input valid, input q_value, input no_point, output ready);
endinterface

[design/dtq_front.sv]
module dtq_front
  import dtq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [7:0] in_char,
  output logic     deq_valid,
  input  logic     deq_ready,
  output op_beat_t deq_beat
);

  op_beat_t          queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  op_beat_t          enq_beat;
  logic              push, pop;

  always_comb begin
    enq_beat.digit = in_char[3:0];
    if (in_char == CH_NUL) begin
      enq_beat.op = OP_TERM;
    end else if (in_char inside {[CH_ZERO:CH_NINE]}) begin
      enq_beat.op = OP_DIGIT;
    end else if (in_char inside {CH_DOT, CH_COMMA}) begin
      enq_beat.op = OP_POINT;
    end else begin
      enq_beat.op = OP_OTHER;
    end
  end

  assign in_ready  = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign deq_valid = (count_r != '0);
  assign deq_beat  = queue_r[rptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = deq_valid && deq_ready;

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wptr_r] <= enq_beat;
    end
  end

endmodule

[design/dtq_back.sv]
module dtq_back
  import dtq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [QW-1:0]      q_bits,
  input  logic               deq_valid,
  output logic               deq_ready,
  input  op_beat_t           deq_beat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WHOLE_W-1:0] out_q_value,
  output logic               out_no_point
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_MUL,
    S_ROUND
  } state_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_WHOLE,
    PH_SEARCH,
    PH_FRAC,
    PH_DONE
  } phase_t;

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [WHOLE_W-1:0] whole_r, whole_nxt;
  logic [FRAC_W-1:0]  resid_r, resid_nxt;
  logic [FRAC_W-1:0]  weight_r, weight_nxt;
  logic [QW-1:0]      bits_r, bits_nxt;
  logic [3:0]         digit_r, digit_nxt;
  logic               term_r, term_nxt;
  logic [FRAC_W-1:0]  sum_r, sum_nxt;
  logic [FRAC_W-1:0]  diff_r, diff_nxt;
  logic               ge_r, ge_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WHOLE_W-1:0] q_value_r, q_value_nxt;
  logic               no_point_r, no_point_nxt;

  logic [FRAC_W:0]    wide_diff;
  logic [FRAC_W-1:0]  kept;
  logic [QW-1:0]      q_eff;
  logic               take;

  assign q_eff     = eff_q(q_bits);
  assign take      = (state_r == S_IDLE) && deq_valid &&
                     ((deq_beat.op != OP_TERM) || !out_valid_r);
  assign deq_ready = take;
  assign out_valid    = out_valid_r;
  assign out_q_value  = q_value_r;
  assign out_no_point = no_point_r;

  always_comb begin
    wide_diff = '0;
    kept      = ge_r ? diff_r : sum_r;

    state_nxt     = state_r;
    phase_nxt     = phase_r;
    whole_nxt     = whole_r;
    resid_nxt     = resid_r;
    weight_nxt    = weight_r;
    bits_nxt      = bits_r;
    digit_nxt     = digit_r;
    term_nxt      = term_r;
    sum_nxt       = sum_r;
    diff_nxt      = diff_r;
    ge_nxt        = ge_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_value_nxt   = q_value_r;
    no_point_nxt  = no_point_r;

    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (deq_beat.op)
            OP_TERM: begin
              if (phase_r inside {PH_FRAC, PH_DONE}) begin
                term_nxt  = 1'b1;
                digit_nxt = '0;
                state_nxt = (bits_r != '0) ? S_ADD : S_ROUND;
              end else begin
                out_valid_nxt = 1'b1;
                q_value_nxt   = whole_r << q_eff;
                no_point_nxt  = 1'b1;
                phase_nxt     = PH_LEAD;
                whole_nxt     = '0;
                resid_nxt     = '0;
                weight_nxt    = WEIGHT_RESET;
                bits_nxt      = '0;
              end
            end
            OP_DIGIT: begin
              if (phase_r inside {PH_LEAD, PH_WHOLE}) begin
                if (!(phase_r == PH_LEAD && deq_beat.digit == 4'd0)) begin
                  whole_nxt = (whole_r << 3) + (whole_r << 1) +
                              WHOLE_W'(deq_beat.digit);
                  phase_nxt = PH_WHOLE;
                end
              end else if (phase_r == PH_FRAC && bits_r != '0) begin
                term_nxt  = 1'b0;
                digit_nxt = deq_beat.digit;
                state_nxt = S_ADD;
              end
            end
            OP_POINT: begin
              if (phase_r inside {PH_LEAD, PH_WHOLE, PH_SEARCH}) begin
                whole_nxt = whole_r << q_eff;
                bits_nxt  = q_eff;
                phase_nxt = PH_FRAC;
              end else if (phase_r == PH_FRAC) begin
                phase_nxt = PH_DONE;
              end
            end
            OP_OTHER: begin
              if (phase_r inside {PH_LEAD, PH_WHOLE}) begin
                phase_nxt = PH_SEARCH;
              end else if (phase_r == PH_FRAC) begin
                phase_nxt = PH_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ADD: begin
        sum_nxt   = resid_r + FRAC_W'(digit_r);
        wide_diff = {1'b0, sum_nxt} - {1'b0, weight_r};
        diff_nxt  = wide_diff[FRAC_W-1:0];
        ge_nxt    = !wide_diff[FRAC_W];
        bits_nxt  = bits_r - 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        whole_nxt  = whole_r + (WHOLE_W'(ge_r) << bits_r);
        resid_nxt  = (kept << 3) + (kept << 1);
        weight_nxt = (weight_r << 2) + weight_r;
        digit_nxt  = '0;
        if (!term_r) begin
          state_nxt = S_IDLE;
        end else if (bits_r != '0) begin
          state_nxt = S_ADD;
        end else begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        out_valid_nxt = 1'b1;
        q_value_nxt   = whole_r + WHOLE_W'(resid_r >= weight_r);
        no_point_nxt  = 1'b0;
        phase_nxt     = PH_LEAD;
        whole_nxt     = '0;
        resid_nxt     = '0;
        weight_nxt    = WEIGHT_RESET;
        bits_nxt      = '0;
        term_nxt      = 1'b0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_LEAD;
      whole_r     <= '0;
      resid_r     <= '0;
      weight_r    <= WEIGHT_RESET;
      bits_r      <= '0;
      term_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      whole_r     <= whole_nxt;
      resid_r     <= resid_nxt;
      weight_r    <= weight_nxt;
      bits_r      <= bits_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
    digit_r    <= digit_nxt;
    sum_r      <= sum_nxt;
    diff_r     <= diff_nxt;
    ge_r       <= ge_nxt;
    q_value_r  <= q_value_nxt;
    no_point_r <= no_point_nxt;
  end

endmodule

[design/decimal_text_to_q_fixed.sv]
// Channel | Direction | Beat fields
// in_chan  | sink      | char_in[7:0]
// out_chan | source    | q_value[31:0], no_point
// cfg      | APB slave | q_bits[4:0] at byte address 0
//
// The front classifies one character per cycle, unless full, into a two-entry queue.
// In S_IDLE the back retires one beat per cycle; a fraction digit runs S_ADD, S_MUL.
// A terminator after a point runs S_ADD, S_MUL per open fraction bit, then S_ROUND.
// The back holds a terminator while an earlier result still waits in the output register.
// Reset is synchronous and active low and needs no clearing pass.
module decimal_text_to_q_fixed
  import dtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dtq_in_if.sink      in_chan,
  dtq_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [QW-1:0] q_bits_r, q_bits_nxt;
  logic          deq_valid, deq_ready;
  op_beat_t      deq_beat;
  logic          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_Q_BITS);
  assign q_bits_nxt = cfg_write ? pwdata[QW-1:0] : q_bits_r;
  assign prdata    = (paddr[2] == REG_Q_BITS) ? {{(32-QW){1'b0}}, q_bits_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_bits_r <= Q_BITS_RESET;
    end else begin
      q_bits_r <= q_bits_nxt;
    end
  end

  dtq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_char   (in_chan.char_in),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_beat  (deq_beat)
  );

  dtq_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_bits       (q_bits_r),
    .deq_valid    (deq_valid),
    .deq_ready    (deq_ready),
    .deq_beat     (deq_beat),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_q_value  (out_chan.q_value),
    .out_no_point (out_chan.no_point)
  );

endmodule
